/* src/jrf_pkg.sv */
// Shared types, constants and state codes of the journal record framer.
package jrf_pkg;

  localparam int CS_WIDTH = 21;
  localparam int DIV_WIDTH = 49;
  localparam int SECTOR_WORDS = 128;

  localparam logic [31:0] TAG_BITMAP = 32'h3F2A_B8ED;
  localparam logic [31:0] TAG_TABLE = 32'hB4E6_F7AC;
  localparam logic [31:0] TAG_EMPTY = 32'h0000_0000;

  localparam logic REG_CHUNK_SECTORS = 1'b0;
  localparam logic REG_RECORD_MODE = 1'b1;

  localparam logic [1:0] MODE_BITMAP = 2'd0;
  localparam logic [1:0] MODE_MIXED = 2'd2;

  localparam logic OP_REQUEST = 1'b0;

  typedef struct packed {
    logic        op;
    logic [47:0] start_sector;
    logic [31:0] sector_count;
    logic [31:0] table_entry;
  } item_t;

  typedef struct packed {
    logic [31:0] word;
    logic        sector_end;
    logic        request_end;
    logic        run_last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_FIRST,
    ST_DIV_LAST,
    ST_MUL,
    ST_SUM,
    ST_CLAMP,
    ST_COUNT,
    ST_HDR_TAG,
    ST_HDR_CHUNK,
    ST_HDR_COUNT,
    ST_ENTRY,
    ST_BM_TAG,
    ST_BM_COUNT,
    ST_BM_LO,
    ST_BM_HI,
    ST_EMPTY
  } state_t;

endpackage

/* src/jrf_fifo.sv */
// Small register queue used on the input and result sides.
module jrf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

/* src/jrf_div.sv */
// Restoring divider, one quotient bit per cycle.
module jrf_div import jrf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_WIDTH-1:0] dividend,
  input  logic [CS_WIDTH-1:0]  divisor,
  output logic                 done,
  output logic [DIV_WIDTH-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_WIDTH);

  logic [CS_WIDTH-1:0] rem;
  logic [CNT_W-1:0]    cnt;
  logic                running;
  logic [CS_WIDTH:0]   trial;
  logic                fits;

  assign trial = {rem, quotient[DIV_WIDTH-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_WIDTH - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (running) begin
      rem      <= fits ? CS_WIDTH'(trial - {1'b0, divisor}) : trial[CS_WIDTH-1:0];
      quotient <= {quotient[DIV_WIDTH-2:0], fits};
    end
  end

endmodule

/* src/jrf_back.sv */
// Record sequencer: chunk arithmetic and word emission.
module jrf_back import jrf_pkg::*; #(
  parameter int TABLE_ENTRIES_PER_SECTOR = 125,
  parameter int MIXED_ENTRIES_PER_SECTOR = 121
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  item_t               item,
  output logic                item_pop,
  input  logic [CS_WIDTH-1:0] chunk_sectors,
  input  logic [1:0]          record_mode,
  input  logic                out_full,
  output logic                out_push,
  output result_t             out_result
);

  localparam logic [6:0] TABLE_LIM = 7'(TABLE_ENTRIES_PER_SECTOR);
  localparam logic [6:0] MIXED_LIM = 7'(MIXED_ENTRIES_PER_SECTOR);
  localparam int MCW = $clog2(CS_WIDTH);

  state_t state;
  state_t state_next;

  logic [47:0]          req_first_sector;
  logic [48:0]          req_end_sector;
  logic [47:0]          cur_chunk;
  logic [32:0]          chunks_left;
  logic [6:0]           slot_in_sector;
  logic [47:0]          rec_start_sector;
  logic [31:0]          rec_sector_count;
  logic [6:0]           sector_chunks;
  logic                 busy;
  logic [31:0]          entry;
  logic                 cnt_zero;
  logic                 mixed;
  logic                 done;
  logic                 need_empty;
  logic [63:0]          mul_acc;
  logic [63:0]          mul_cand;
  logic [CS_WIDTH-1:0]  mul_plier;
  logic [MCW-1:0]       mul_cnt;
  logic [27:0]          n_cs;
  logic [63:0]          hi_sum;
  logic [63:0]          lo_c;
  logic [63:0]          hi_c;

  logic                 div_start;
  logic [DIV_WIDTH-1:0] div_dividend;
  logic                 div_done;
  logic [DIV_WIDTH-1:0] div_quot;

  logic                 mixed_in;
  logic [6:0]           lim;
  logic [6:0]           n_first;
  logic                 close_c;
  logic                 done_c;
  logic                 need_empty_c;
  logic [7:0]           words_c;
  logic                 emit_state;

  assign mixed_in = (record_mode >= MODE_MIXED);
  assign lim      = mixed_in ? MIXED_LIM : TABLE_LIM;
  assign n_first  = (chunks_left < {26'd0, lim}) ? chunks_left[6:0] : lim;
  assign close_c  = ({1'b0, slot_in_sector} + 8'd1) >= {1'b0, sector_chunks};
  assign done_c   = (chunks_left == 33'd1);
  assign words_c  = 8'd3 + {1'b0, sector_chunks} + (mixed ? 8'd4 : 8'd0);
  assign need_empty_c = (words_c < 8'(SECTOR_WORDS));

  assign div_dividend = (state == ST_IDLE) ? {1'b0, item.start_sector}
                                           : (req_end_sector - 49'd1);

  jrf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (chunk_sectors),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (item.op == OP_REQUEST) begin
            state_next = (record_mode == MODE_BITMAP) ? ST_BM_TAG : ST_DIV_FIRST;
          end else if (busy) begin
            state_next = (slot_in_sector == '0) ? ST_MUL : ST_ENTRY;
          end
        end
      end
      ST_DIV_FIRST: begin
        if (div_done) begin
          state_next = cnt_zero ? ST_IDLE : ST_DIV_LAST;
        end
      end
      ST_DIV_LAST: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        if (mul_cnt == MCW'(CS_WIDTH - 1)) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_COUNT;
      ST_COUNT: state_next = ST_HDR_TAG;
      ST_HDR_TAG: begin
        if (!out_full) state_next = ST_HDR_CHUNK;
      end
      ST_HDR_CHUNK: begin
        if (!out_full) state_next = ST_HDR_COUNT;
      end
      ST_HDR_COUNT: begin
        if (!out_full) state_next = ST_ENTRY;
      end
      ST_ENTRY: begin
        if (!out_full) begin
          if (!close_c) begin
            state_next = ST_IDLE;
          end else if (mixed) begin
            state_next = ST_BM_TAG;
          end else begin
            state_next = need_empty_c ? ST_EMPTY : ST_IDLE;
          end
        end
      end
      ST_BM_TAG: begin
        if (!out_full) state_next = ST_BM_COUNT;
      end
      ST_BM_COUNT: begin
        if (!out_full) state_next = ST_BM_LO;
      end
      ST_BM_LO: begin
        if (!out_full) state_next = ST_BM_HI;
      end
      ST_BM_HI: begin
        if (!out_full) state_next = need_empty ? ST_EMPTY : ST_IDLE;
      end
      ST_EMPTY: begin
        if (!out_full) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_pop   = (state == ST_IDLE) && item_valid;
    div_start  = 1'b0;
    emit_state = 1'b0;
    out_result = '0;
    unique case (state)
      ST_IDLE: begin
        div_start = item_valid && (item.op == OP_REQUEST) && (record_mode != MODE_BITMAP);
      end
      ST_DIV_FIRST: begin
        div_start = div_done && !cnt_zero;
      end
      ST_HDR_TAG: begin
        emit_state      = 1'b1;
        out_result.word = TAG_TABLE;
      end
      ST_HDR_CHUNK: begin
        emit_state      = 1'b1;
        out_result.word = cur_chunk[31:0];
      end
      ST_HDR_COUNT: begin
        emit_state      = 1'b1;
        out_result.word = {25'd0, sector_chunks};
      end
      ST_ENTRY: begin
        emit_state             = 1'b1;
        out_result.word        = entry;
        out_result.run_last    = !close_c;
        out_result.sector_end  = close_c && !mixed && !need_empty_c;
        out_result.request_end = close_c && !mixed && !need_empty_c && done_c;
        if (close_c && !mixed && !need_empty_c) begin
          out_result.run_last = 1'b1;
        end
      end
      ST_BM_TAG: begin
        emit_state      = 1'b1;
        out_result.word = TAG_BITMAP;
      end
      ST_BM_COUNT: begin
        emit_state      = 1'b1;
        out_result.word = rec_sector_count;
      end
      ST_BM_LO: begin
        emit_state      = 1'b1;
        out_result.word = rec_start_sector[31:0];
      end
      ST_BM_HI: begin
        emit_state             = 1'b1;
        out_result.word        = {16'd0, rec_start_sector[47:32]};
        out_result.run_last    = !need_empty;
        out_result.sector_end  = !need_empty;
        out_result.request_end = !need_empty && done;
      end
      ST_EMPTY: begin
        emit_state             = 1'b1;
        out_result.word        = TAG_EMPTY;
        out_result.run_last    = 1'b1;
        out_result.sector_end  = 1'b1;
        out_result.request_end = done;
      end
      default: begin
      end
    endcase
    out_push = emit_state && !out_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      req_first_sector <= '0;
      req_end_sector   <= '0;
      cur_chunk        <= '0;
      chunks_left      <= '0;
      slot_in_sector   <= '0;
      rec_start_sector <= '0;
      rec_sector_count <= '0;
      sector_chunks    <= '0;
      busy             <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            if (item.op == OP_REQUEST) begin
              req_first_sector <= item.start_sector;
              req_end_sector   <= {1'b0, item.start_sector} + {17'd0, item.sector_count};
              slot_in_sector   <= '0;
              sector_chunks    <= '0;
              if (record_mode == MODE_BITMAP) begin
                busy             <= 1'b0;
                chunks_left      <= '0;
                rec_start_sector <= item.start_sector;
                rec_sector_count <= item.sector_count;
              end else begin
                busy <= 1'b1;
              end
            end else if (busy && slot_in_sector == '0) begin
              sector_chunks <= n_first;
            end
          end
        end
        ST_DIV_FIRST: begin
          if (div_done) begin
            cur_chunk <= div_quot[47:0];
            if (cnt_zero) begin
              chunks_left <= 33'd1;
            end
          end
        end
        ST_DIV_LAST: begin
          if (div_done) begin
            chunks_left <= 33'(div_quot - {1'b0, cur_chunk} + 49'd1);
          end
        end
        ST_COUNT: begin
          rec_start_sector <= lo_c[47:0];
          rec_sector_count <= hi_c[31:0] - lo_c[31:0];
        end
        ST_ENTRY: begin
          if (!out_full) begin
            slot_in_sector <= close_c ? '0 : slot_in_sector + 7'd1;
            cur_chunk      <= cur_chunk + 48'd1;
            chunks_left    <= chunks_left - 33'd1;
            if (close_c && done_c) begin
              busy <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        entry    <= item.table_entry;
        mixed    <= mixed_in;
        cnt_zero <= (item.sector_count == '0);
        if (item.op == OP_REQUEST) begin
          need_empty <= 1'b1;
          done       <= 1'b1;
        end
        mul_acc   <= '0;
        mul_cand  <= {16'd0, cur_chunk};
        mul_plier <= chunk_sectors;
        mul_cnt   <= '0;
        n_cs      <= 28'(n_first) * 28'(chunk_sectors);
      end
      ST_MUL: begin
        if (mul_plier[0]) begin
          mul_acc <= mul_acc + mul_cand;
        end
        mul_cand  <= {mul_cand[62:0], 1'b0};
        mul_plier <= mul_plier >> 1;
        mul_cnt   <= mul_cnt + 1'b1;
      end
      ST_SUM: begin
        hi_sum <= mul_acc + {36'd0, n_cs};
      end
      ST_CLAMP: begin
        lo_c <= (mul_acc < {16'd0, req_first_sector}) ? {16'd0, req_first_sector} : mul_acc;
        hi_c <= (hi_sum > {15'd0, req_end_sector}) ? {15'd0, req_end_sector} : hi_sum;
      end
      ST_ENTRY: begin
        done       <= done_c;
        need_empty <= need_empty_c;
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/journal_record_framer.sv */
// Journal record framer top level: queues, configuration and sequencer.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------
//   input    | push / full         | item   (item_t)
//   result   | pop / empty         | result (result_t)
//   config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A bitmap-only request produces 5 result words.
// A table request runs one 49-step division, two if its count is nonzero.
// An entry emits its words; the first entry of a sector first runs
// the 21-step chunk multiply and the sum, clamp and count steps.
// Reset is synchronous; a full result queue stalls the sequencer, and the
// input queue then fills and raises full.
module journal_record_framer import jrf_pkg::*; #(
  parameter int TABLE_ENTRIES_PER_SECTOR = 125,
  parameter int MIXED_ENTRIES_PER_SECTOR = 121
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  item_t               item,
  input  logic                pop,
  output logic                empty,
  output result_t             result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [CS_WIDTH-1:0] cfg_data
);

  logic [CS_WIDTH-1:0] chunk_sectors;
  logic [1:0]          record_mode;
  logic [CS_WIDTH-1:0] cs_eff;
  logic                fq_empty;
  item_t               fq_item;
  logic                fq_pop;
  logic                oq_full;
  logic                oq_push;
  result_t             oq_wdata;

  assign cfg_ready = 1'b1;
  assign cs_eff    = (chunk_sectors == '0) ? CS_WIDTH'(1) : chunk_sectors;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_sectors <= CS_WIDTH'(2048);
      record_mode   <= MODE_MIXED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHUNK_SECTORS: chunk_sectors <= cfg_data;
        REG_RECORD_MODE:   record_mode   <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  jrf_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (2)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (item),
    .pop   (fq_pop),
    .empty (fq_empty),
    .rdata (fq_item)
  );

  jrf_back #(
    .TABLE_ENTRIES_PER_SECTOR (TABLE_ENTRIES_PER_SECTOR),
    .MIXED_ENTRIES_PER_SECTOR (MIXED_ENTRIES_PER_SECTOR)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (!fq_empty),
    .item          (fq_item),
    .item_pop      (fq_pop),
    .chunk_sectors (cs_eff),
    .record_mode   (record_mode),
    .out_full      (oq_full),
    .out_push      (oq_push),
    .out_result    (oq_wdata)
  );

  jrf_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_result (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .full  (oq_full),
    .wdata (oq_wdata),
    .pop   (pop),
    .empty (empty),
    .rdata (result)
  );

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the journal record framer.
module testbench;
  import jrf_pkg::*;

  localparam logic       OP_ENTRY   = 1'b1;
  localparam logic [1:0] MODE_TABLE = 2'd1;
  localparam logic [1:0] MODE_ALIAS = 2'd3;
  localparam int         TABLE_ENTRIES_PER_SECTOR = 125;
  localparam int         MIXED_ENTRIES_PER_SECTOR = 121;
  localparam int         ITEM_TARGET = 380;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         SETTLE_CYCLES = 200;
  localparam int         HOLD_CYCLES = 400;

  class framer_scoreboard;
    logic [63:0] chunk_sectors = 2048;
    logic [1:0]  record_mode = MODE_MIXED;
    logic [63:0] req_first_sector, req_end_sector, cur_chunk, chunks_left;
    logic [63:0] rec_start_sector, rec_sector_count;
    int          slot_in_sector, sector_chunks;
    bit          busy;
    result_t     pending[$];
    int          errors, items_taken, entries_ignored, results_seen, reg_writes;

    function new();
      req_first_sector = 0;
      req_end_sector = 0;
      cur_chunk = 0;
      chunks_left = 0;
      rec_start_sector = 0;
      rec_sector_count = 0;
      slot_in_sector = 0;
      sector_chunks = 0;
      busy = 0;
    endfunction

    function void set_register(logic idx, logic [CS_WIDTH-1:0] value);
      reg_writes++;
      if (idx == REG_CHUNK_SECTORS) chunk_sectors = {43'd0, value};
      else record_mode = value[1:0];
    endfunction

    function void put(logic [31:0] w);
      result_t r;
      r.word = w;
      r.sector_end = 0;
      r.request_end = 0;
      r.run_last = 0;
      pending.push_back(r);
    endfunction

    function void put_bitmap();
      put(TAG_BITMAP);
      put(rec_sector_count[31:0]);
      put(rec_start_sector[31:0]);
      put({16'd0, rec_start_sector[47:32]});
    endfunction

    function void note_item(item_t it);
      logic [63:0] cs, start, cnt, first, last, lo, hi, n, lim, words;
      int base;
      bit mixed, done;
      cs = (chunk_sectors == 0) ? 64'd1 : chunk_sectors;
      mixed = record_mode >= MODE_MIXED;
      base = pending.size();
      items_taken++;
      if (it.op == OP_REQUEST) begin
        start = {16'd0, it.start_sector};
        cnt = {32'd0, it.sector_count};
        first = start / cs;
        last = (cnt != 0) ? (start + cnt - 1) / cs : first;
        req_first_sector = start;
        req_end_sector = start + cnt;
        cur_chunk = first;
        slot_in_sector = 0;
        sector_chunks = 0;
        if (record_mode == MODE_BITMAP) begin
          busy = 0;
          chunks_left = 0;
          rec_start_sector = start;
          rec_sector_count = cnt;
          put_bitmap();
          put(TAG_EMPTY);
          pending[pending.size()-1].sector_end = 1;
          pending[pending.size()-1].request_end = 1;
        end else begin
          busy = 1;
          chunks_left = last - first + 1;
        end
      end else if (!busy) begin
        entries_ignored++;
      end else begin
        if (slot_in_sector == 0) begin
          lim = mixed ? MIXED_ENTRIES_PER_SECTOR : TABLE_ENTRIES_PER_SECTOR;
          n = (chunks_left < lim) ? chunks_left : lim;
          lo = cur_chunk * cs;
          hi = (cur_chunk + n) * cs;
          if (lo < req_first_sector) lo = req_first_sector;
          if (hi > req_end_sector) hi = req_end_sector;
          sector_chunks = int'(n);
          rec_start_sector = lo & 64'hFFFF_FFFF_FFFF;
          rec_sector_count = (hi - lo) & 64'hFFFF_FFFF;
          put(TAG_TABLE);
          put(cur_chunk[31:0]);
          put(n[31:0]);
        end
        put(it.table_entry);
        slot_in_sector++;
        cur_chunk = (cur_chunk + 1) & 64'hFFFF_FFFF_FFFF;
        chunks_left--;
        if (slot_in_sector >= sector_chunks) begin
          words = 3 + sector_chunks;
          done = chunks_left == 0;
          if (mixed) begin
            put_bitmap();
            words += 4;
          end
          if (words < SECTOR_WORDS) put(TAG_EMPTY);
          pending[pending.size()-1].sector_end = 1;
          pending[pending.size()-1].request_end = done;
          slot_in_sector = 0;
          if (done) busy = 0;
        end
      end
      if (pending.size() > base) pending[pending.size()-1].run_last = 1;
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, got.word);
        return;
      end
      want = pending.pop_front();
      if (got.word !== want.word) begin
        errors++;
        $display("%0t: word expected %h actual %h", $time, want.word, got.word);
      end
      if (got.sector_end !== want.sector_end) begin
        errors++;
        $display("%0t: sector_end expected %b actual %b", $time,
                 want.sector_end, got.sector_end);
      end
      if (got.request_end !== want.request_end) begin
        errors++;
        $display("%0t: request_end expected %b actual %b", $time,
                 want.request_end, got.request_end);
      end
      if (got.run_last !== want.run_last) begin
        errors++;
        $display("%0t: run_last expected %b actual %b", $time,
                 want.run_last, got.run_last);
      end
    endfunction
  endclass

  logic                clk = 0;
  logic                rst = 1;
  logic                push = 0;
  logic                full;
  item_t               item = '0;
  logic                pop = 0;
  logic                empty;
  result_t             result;
  logic                cfg_valid = 0;
  logic                cfg_ready;
  logic                cfg_index = 0;
  logic [CS_WIDTH-1:0] cfg_data = '0;

  framer_scoreboard sb = new();
  bit idle_on = 1;
  bit hold_go = 0;
  int hold_left = 0;
  int cycles = 0;

  journal_record_framer u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .pop(pop), .empty(empty), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** journal_record_framer: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (pop && !empty) sb.check_result(result);
    if (rst) begin
      pop <= 0;
    end else if (hold_left > 0) begin
      pop <= 0;
      hold_left--;
    end else if (hold_go) begin
      hold_go = 0;
      hold_left = HOLD_CYCLES;
      pop <= 0;
    end else begin
      pop <= idle_on ? ($urandom_range(99) >= 38) : 1'b1;
    end
  end

  task automatic send_item(input item_t it);
    if (idle_on) begin
      while ($urandom_range(99) < 38) begin
        push <= 0;
        @(posedge clk);
      end
    end
    push <= 1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic send_request(input logic [47:0] start, input logic [31:0] cnt);
    item_t it;
    it = '0;
    it.op = OP_REQUEST;
    it.start_sector = start;
    it.sector_count = cnt;
    it.table_entry = $urandom;
    send_item(it);
  endtask

  task automatic send_entries(input int n);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it.op = OP_ENTRY;
      it.start_sector = 48'({$urandom, $urandom});
      it.sector_count = $urandom;
      it.table_entry = $urandom;
      send_item(it);
    end
  endtask

  task automatic settle();
    push <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CS_WIDTH-1:0] value);
    settle();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, value);
    cfg_valid <= 0;
  endtask

  task automatic random_request();
    logic [63:0] cs, cnt;
    logic [47:0] start;
    int nch, roll, n;
    cs = (sb.chunk_sectors == 0) ? 64'd1 : sb.chunk_sectors;
    nch = ($urandom_range(11) == 0) ? $urandom_range(118, 130) : $urandom_range(1, 4);
    start = ($urandom_range(3) == 0) ? 48'($urandom_range(4096)) : 48'({$urandom, $urandom});
    roll = $urandom_range(99);
    if (roll < 10) cnt = $urandom;
    else if (roll < 15) cnt = 0;
    else cnt = nch * cs - $urandom_range(0, int'(cs - 1));
    send_request(start, cnt[31:0]);
    if (sb.record_mode == MODE_BITMAP) return;
    n = int'((sb.chunks_left > 135) ? 64'($urandom_range(1, 6)) : sb.chunks_left);
    roll = $urandom_range(99);
    if (roll < 10) n = $urandom_range(0, n - 1);
    send_entries(n);
    if (roll >= 90) send_entries($urandom_range(1, 2));
  endtask

  logic [CS_WIDTH-1:0] cs_set[8] = '{21'd1, 21'd1048576, 21'd7, 21'h1FFFFF,
                                     21'd2048, 21'd0, 21'd3, 21'd640};
  logic [1:0] mode_set[4] = '{MODE_TABLE, MODE_MIXED, MODE_BITMAP, MODE_ALIAS};

  initial begin
    int phase;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_entries(1);
    send_request(48'd0, 32'd1);
    send_entries(1);
    send_request(48'd2047, 32'd2);
    send_entries(2);
    send_request(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_entries(2);
    send_request(48'd100, 32'd0);
    send_entries(1);
    write_reg(REG_RECORD_MODE, 21'(MODE_BITMAP));
    send_request(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(48'd0, 32'd0);
    send_request(48'({$urandom, $urandom}), 32'd1);
    write_reg(REG_RECORD_MODE, 21'(MODE_ALIAS));
    write_reg(REG_CHUNK_SECTORS, 21'd0);
    send_request(48'd5, 32'd3);
    send_entries(3);
    write_reg(REG_RECORD_MODE, 21'(MODE_TABLE));
    write_reg(REG_CHUNK_SECTORS, 21'd1048576);
    send_request(48'd1048575, 32'd1);
    send_entries(1);

    write_reg(REG_CHUNK_SECTORS, 21'd1);
    hold_go = 1;
    send_request(48'd77, 32'd126);
    send_entries(126);
    settle();

    idle_on = 0;
    phase = 0;
    while (sb.items_taken < ITEM_TARGET) begin
      write_reg(REG_CHUNK_SECTORS, cs_set[phase % 8]);
      write_reg(REG_RECORD_MODE, 21'(mode_set[phase % 4]));
      if (phase == 2) idle_on = 1;
      for (int k = 0; k < 12 && sb.items_taken < ITEM_TARGET; k++) begin
        random_request();
        if (k == 6) settle();
      end
      phase++;
    end
    settle();

    $display("run took %0d items (%0d entries ignored), %0d results, %0d register writes",
             sb.items_taken, sb.entries_ignored, sb.results_seen, sb.reg_writes);
    $display("modes bitmap, table, mixed and alias; chunk sizes from 0 to 21 bits wide");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** journal_record_framer: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results left over", sb.errors, sb.pending.size());
      $display("** journal_record_framer: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/jrf_pkg.sv
src/jrf_fifo.sv
src/jrf_div.sv
src/jrf_back.sv
src/journal_record_framer.sv
bench/testbench.sv
